// ----- rtl/core/dna_two_bit_packer_core_macros.svh -----
// Assertion macros for the DNA two-bit packer core.
// Included by the top level; needs nothing else.
`ifndef DNA_TWO_BIT_PACKER_CORE_MACROS_SVH
`define DNA_TWO_BIT_PACKER_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DTBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dtbp assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define DTBP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dtbp assertion failed");

`endif

// ----- rtl/core/dtbp_pkg.sv -----
// Shared types and constants of the DNA two-bit packer core.
// No dependencies; imported by dtbp_step, dna_two_bit_packer_core and dtbp_checker.
`timescale 1ns / 1ps

package dtbp_pkg;

    localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_NRUN  = 2'd1,
        KIND_MASK  = 2'd2
    } t_kind;

    // One result record.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  packed_byte;
        logic [31:0] run_start;
        logic [31:0] run_length;
        logic        final_result;
    } t_rec;

    // Sequence state carried from item to item.
    typedef struct packed {
        logic [31:0] position;
        logic [5:0]  pending_codes;
        logic [1:0]  pending_count;
        logic        in_n_run;
        logic [31:0] n_run_start;
        logic        in_mask_run;
        logic [31:0] mask_run_start;
    } t_state;

endpackage

// ----- rtl/core/dna_two_bit_packer_core.sv -----
// Top level of the DNA two-bit packer: input register, step logic, record buffer.
// Depends on dtbp_pkg, dtbp_step and dna_two_bit_packer_core_macros.svh.
//
// Channel   Dir  Carries
// s_axis    in   tdata[7:0] base_char, tlast seq_end
// m_axis    out  tdata[7:0] packed_byte, [39:8] run_start, [71:40] run_length,
//                tuser[1:0] kind, tlast final_result
// cfg       in   data[0] mask_enable
//
// An input request is taken every cycle while the record buffer drains in time;
// each item yields zero to three records, sent one per cycle on the output while
// it is ready, so the rate is set by the output port.
// An item passes the input register, then the record buffer, before its first record.
// Reset clears the sequence state and empties both registers; mask_enable
// returns to 1. A stalled output holds the buffer; one item waits in the
// input register meanwhile.
`timescale 1ns / 1ps

`include "dna_two_bit_packer_core_macros.svh"

module dna_two_bit_packer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] base_char
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // [7:0] packed_byte, [39:8] run_start,
                                          // [71:40] run_length
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_data        // [0] mask_enable
);
    import dtbp_pkg::*;

    logic       r_mask_en;
    logic       r_in_v;
    logic [7:0] r_in_char;
    logic       r_in_last;
    t_state     r_state;
    t_state     n_state;
    t_rec       r_rec [3];
    t_rec       n_rec [3];
    logic [2:0] r_bv;
    logic [2:0] n_bv;
    logic [2:0] step_v;

    logic       in_fire;
    logic       out_fire;
    logic       buf_free;
    logic       move;
    logic [1:0] sel;
    logic [2:0] sel_mask;

    dtbp_step u_step (
        .i_state       (r_state),
        .i_base_char   (r_in_char),
        .i_seq_end     (r_in_last),
        .i_mask_enable (r_mask_en),
        .o_state       (n_state),
        .o_rec         (n_rec),
        .o_rec_valid   (step_v)
    );

    always_comb begin
        if (r_bv[0]) begin
            sel = 2'd0;
        end else if (r_bv[1]) begin
            sel = 2'd1;
        end else begin
            sel = 2'd2;
        end
        sel_mask = 3'b001 << sel;
        o_m_axis_tvalid = |r_bv;
        o_m_axis_tdata  = {r_rec[sel].run_length, r_rec[sel].run_start,
                           r_rec[sel].packed_byte};
        o_m_axis_tuser  = r_rec[sel].kind;
        o_m_axis_tlast  = r_rec[sel].final_result;

        out_fire = o_m_axis_tvalid && i_m_axis_tready;
        // The buffer is free when empty or when its only remaining record leaves now.
        buf_free = (r_bv == 3'b000) || (($countones(r_bv) == 1) && out_fire);
        move     = r_in_v && buf_free;
        o_s_axis_tready = !r_in_v || buf_free;
        in_fire  = i_s_axis_tvalid && o_s_axis_tready;
        o_cfg_ready = 1'b1;

        n_bv = r_bv & ~(out_fire ? sel_mask : 3'b000);
        if (move)
            n_bv = step_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_en <= 1'b1;
        end else if (i_cfg_valid) begin
            r_mask_en <= i_cfg_data[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_bv    <= 3'b000;
            r_state <= '0;
        end else begin
            if (in_fire)
                r_in_v <= 1'b1;
            else if (move)
                r_in_v <= 1'b0;
            r_bv <= n_bv;
            if (move)
                r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_char <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
        if (move) begin
            r_rec[0] <= n_rec[0];
            r_rec[1] <= n_rec[1];
            r_rec[2] <= n_rec[2];
        end
    end

    // The record marked final is always the last one left in the buffer.
    `DTBP_ASSERT_IMP(a_last_is_final, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tlast, $countones(r_bv) == 1)
    // A stalled input means an item is held in the input register.
    `DTBP_ASSERT_IMP(a_stall_holds_item, i_clk, i_rst_n, !o_s_axis_tready, r_in_v)
    // Each output request without a refill removes exactly one record.
    `DTBP_ASSERT_NXT(a_drain_one, i_clk, i_rst_n, out_fire && !move,
        $countones(r_bv) == $countones($past(r_bv)) - 1)

endmodule

// ----- rtl/core/dtbp_step.sv -----
// Per-item logic of the DNA two-bit packer: next state and up to three records.
// Depends on dtbp_pkg.
`timescale 1ns / 1ps

module dtbp_step (
    input  dtbp_pkg::t_state i_state,
    input  logic [7:0]       i_base_char,
    input  logic             i_seq_end,
    input  logic             i_mask_enable,
    output dtbp_pkg::t_state o_state,
    output dtbp_pkg::t_rec   o_rec [3],
    output logic [2:0]       o_rec_valid
);
    import dtbp_pkg::*;

    function automatic logic [1:0] base_code(input logic [7:0] c);
        case (c)
            8'h43, 8'h63: base_code = 2'd1;
            8'h41, 8'h61: base_code = 2'd2;
            8'h47, 8'h67: base_code = 2'd3;
            default:      base_code = 2'd0;
        endcase
    endfunction

    // Length from start to position, optionally including the current base,
    // clamped to 1..2^32-1.
    function automatic logic [31:0] run_len(input logic [31:0] start,
                                            input logic [31:0] pos,
                                            input logic        incl);
        logic [32:0] diff;
        diff = {1'b0, pos} - {1'b0, start} + {32'd0, incl};
        if (diff[32])
            run_len = POS_MAX;
        else if (diff[31:0] == 32'd0)
            run_len = 32'd1;
        else
            run_len = diff[31:0];
    endfunction

    logic [1:0]  code;
    logic        is_n;
    logic        is_low;
    logic        byte_out;
    logic [7:0]  byte_val;
    logic        n_emit;
    logic        m_emit;
    logic [31:0] n_start;
    logic [31:0] m_start;
    logic [2:0]  vld;

    always_comb begin
        code   = base_code(i_base_char);
        is_n   = (i_base_char == 8'h4E) || (i_base_char == 8'h6E);
        is_low = i_mask_enable && (i_base_char >= 8'h61) && (i_base_char <= 8'h7A);

        case (i_state.pending_count)
            2'd0:    byte_val = {code, 6'd0};
            2'd1:    byte_val = {i_state.pending_codes[1:0], code, 4'd0};
            2'd2:    byte_val = {i_state.pending_codes[3:0], code, 2'd0};
            default: byte_val = {i_state.pending_codes, code};
        endcase
        byte_out = (i_state.pending_count == 2'd3) || i_seq_end;

        n_start = i_state.in_n_run ? i_state.n_run_start : i_state.position;
        m_start = i_state.in_mask_run ? i_state.mask_run_start : i_state.position;
        n_emit  = is_n ? i_seq_end : i_state.in_n_run;
        m_emit  = is_low ? i_seq_end : i_state.in_mask_run;
        vld     = {m_emit, n_emit, byte_out};

        o_rec[0].kind         = KIND_BYTE;
        o_rec[0].packed_byte  = byte_val;
        o_rec[0].run_start    = 32'd0;
        o_rec[0].run_length   = 32'd0;
        o_rec[0].final_result = !vld[1] && !vld[2];

        o_rec[1].kind         = KIND_NRUN;
        o_rec[1].packed_byte  = 8'd0;
        o_rec[1].run_start    = n_start;
        o_rec[1].run_length   = run_len(n_start, i_state.position, is_n);
        o_rec[1].final_result = !vld[2];

        o_rec[2].kind         = KIND_MASK;
        o_rec[2].packed_byte  = 8'd0;
        o_rec[2].run_start    = m_start;
        o_rec[2].run_length   = run_len(m_start, i_state.position, is_low);
        o_rec[2].final_result = 1'b1;

        o_rec_valid = vld;

        o_state = i_state;
        if (byte_out) begin
            o_state.pending_codes = 6'd0;
            o_state.pending_count = 2'd0;
        end else begin
            // Pending codes sit right-aligned, the newest in the lowest bits.
            o_state.pending_codes = {i_state.pending_codes[3:0], code};
            o_state.pending_count = i_state.pending_count + 2'd1;
        end
        if (i_seq_end) begin
            o_state.position       = 32'd0;
            o_state.in_n_run       = 1'b0;
            o_state.in_mask_run    = 1'b0;
            o_state.n_run_start    = 32'd0;
            o_state.mask_run_start = 32'd0;
        end else begin
            o_state.in_n_run       = is_n;
            o_state.in_mask_run    = is_low;
            o_state.n_run_start    = is_n ? n_start : i_state.n_run_start;
            o_state.mask_run_start = is_low ? m_start : i_state.mask_run_start;
            if (i_state.position != POS_MAX)
                o_state.position = i_state.position + 32'd1;
        end
    end

endmodule

// ----- tb/dtbp_checker.sv -----
`timescale 1ns / 1ps
// Checker for the DNA two-bit packer core: watches the base, record and
// configuration channels, predicts every record and compares it on arrival.
// Depends on dtbp_pkg for the record type, the kind codes and POS_MAX.

module dtbp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] base_char
    input  logic        i_s_axis_tlast,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [71:0] i_m_axis_tdata,   // [7:0] packed_byte, [39:8] run_start,
                                          // [71:40] run_length
    input  logic [1:0]  i_m_axis_tuser,   // [1:0] kind
    input  logic        i_m_axis_tlast,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [0:0]  i_cfg_data,       // [0] mask_enable
    output int          o_mismatches,
    output int          o_outstanding
);
    import dtbp_pkg::*;

    // Local copy of the sequence state and of the mask register.
    logic        mask_en;
    logic [31:0] base_pos;
    logic [5:0]  pend_codes;
    logic [1:0]  pend_count;
    logic        in_n_run;
    logic [31:0] n_start;
    logic        in_mask_run;
    logic [31:0] mask_start;

    t_rec expected_recs[$];
    int   mismatches = 0;

    function automatic logic [1:0] base_code(input logic [7:0] c);
        case (c)
            "C", "c": base_code = 2'd1;
            "A", "a": base_code = 2'd2;
            "G", "g": base_code = 2'd3;
            default:  base_code = 2'd0;
        endcase
    endfunction

    // Run length with the end either inclusive or exclusive of the current
    // base, clamped to the range 1..POS_MAX.
    function automatic logic [31:0] run_span(input logic [31:0] start,
                                             input logic [31:0] pos,
                                             input logic        incl);
        logic [32:0] stop;
        logic [32:0] len;
        stop = {1'b0, pos} + {32'd0, incl};
        len  = (stop > {1'b0, start}) ? stop - {1'b0, start} : 33'd0;
        if (len == 33'd0)
            len = 33'd1;
        if (len > {1'b0, POS_MAX})
            len = {1'b0, POS_MAX};
        return len[31:0];
    endfunction

    function automatic t_rec make_rec(input t_kind k, input logic [7:0] pb,
                                      input logic [31:0] start,
                                      input logic [31:0] len);
        t_rec r;
        r.kind         = k;
        r.packed_byte  = pb;
        r.run_start    = start;
        r.run_length   = len;
        r.final_result = 1'b0;
        return r;
    endfunction

    task automatic predict_records(input logic [7:0] c, input logic seq_end);
        t_rec       recs [3];
        t_rec       r;
        int         n;
        logic       is_n;
        logic       is_low;
        logic [7:0] acc;
        logic [7:0] pb;
        logic [2:0] have;
        n      = 0;
        is_n   = (c == "N") || (c == "n");
        is_low = mask_en && (c >= "a") && (c <= "z");
        acc    = {pend_codes, base_code(c)};
        have   = {1'b0, pend_count} + 3'd1;

        if (have == 3'd4 || seq_end) begin
            pb = acc << (2 * (3'd4 - have));
            recs[n] = make_rec(KIND_BYTE, pb, 32'd0, 32'd0);
            n++;
            pend_codes = '0;
            pend_count = '0;
        end else begin
            pend_codes = acc[5:0];
            pend_count = have[1:0];
        end

        if (is_n) begin
            if (!in_n_run) begin
                in_n_run = 1'b1;
                n_start  = base_pos;
            end
            if (seq_end) begin
                recs[n] = make_rec(KIND_NRUN, 8'd0, n_start,
                                   run_span(n_start, base_pos, 1'b1));
                n++;
            end
        end else if (in_n_run) begin
            recs[n] = make_rec(KIND_NRUN, 8'd0, n_start,
                               run_span(n_start, base_pos, 1'b0));
            n++;
            in_n_run = 1'b0;
        end

        if (is_low) begin
            if (!in_mask_run) begin
                in_mask_run = 1'b1;
                mask_start  = base_pos;
            end
            if (seq_end) begin
                recs[n] = make_rec(KIND_MASK, 8'd0, mask_start,
                                   run_span(mask_start, base_pos, 1'b1));
                n++;
            end
        end else if (in_mask_run) begin
            recs[n] = make_rec(KIND_MASK, 8'd0, mask_start,
                               run_span(mask_start, base_pos, 1'b0));
            n++;
            in_mask_run = 1'b0;
        end

        if (seq_end) begin
            base_pos    = '0;
            in_n_run    = 1'b0;
            in_mask_run = 1'b0;
            n_start     = '0;
            mask_start  = '0;
        end else if (base_pos != POS_MAX) begin
            base_pos = base_pos + 32'd1;
        end

        for (int i = 0; i < n; i++) begin
            r = recs[i];
            if (i == n - 1)
                r.final_result = 1'b1;
            expected_recs.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got, inout logic bad);
        if (want !== got) begin
            $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
            bad = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_rec want;
        logic bad;
        if (!i_rst_n) begin
            mask_en     = 1'b1;
            base_pos    = '0;
            pend_codes  = '0;
            pend_count  = '0;
            in_n_run    = 1'b0;
            n_start     = '0;
            in_mask_run = 1'b0;
            mask_start  = '0;
            expected_recs.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                mask_en = i_cfg_data[0];
            if (i_s_axis_tvalid && i_s_axis_tready)
                predict_records(i_s_axis_tdata, i_s_axis_tlast);
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_recs.size() == 0) begin
                    $display("%0t ns: record expected none actual %h %h %b", $time,
                             i_m_axis_tuser, i_m_axis_tdata, i_m_axis_tlast);
                    mismatches++;
                end else begin
                    want = expected_recs.pop_front();
                    bad  = 1'b0;
                    check_field("kind", {30'd0, want.kind}, {30'd0, i_m_axis_tuser}, bad);
                    check_field("packed_byte", {24'd0, want.packed_byte},
                                {24'd0, i_m_axis_tdata[7:0]}, bad);
                    check_field("run_start", want.run_start, i_m_axis_tdata[39:8], bad);
                    check_field("run_length", want.run_length, i_m_axis_tdata[71:40], bad);
                    check_field("final_result", {31'd0, want.final_result},
                                {31'd0, i_m_axis_tlast}, bad);
                    if (bad)
                        mismatches++;
                end
            end
        end
        o_outstanding = expected_recs.size();
        o_mismatches  = mismatches;
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Top of the DNA two-bit packer testbench: clock, reset, base and mask stimulus
// and the verdict. Depends on dna_two_bit_packer_core and dtbp_checker.

module tb;

    localparam int QUIET_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_data;

    int          src_idle_pct;
    int          sink_idle_pct;
    int          mismatches;
    int          outstanding;
    int          quiet_cycles;
    logic [7:0]  prev_base;

    dna_two_bit_packer_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    dtbp_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .i_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial m_tready = 1'b0;

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

    // Ends the run if no request is taken on any channel for too long.
    initial quiet_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("dna_two_bit_packer_core: mismatch");
                $finish;
            end
        end
    end

    task automatic send_base(input logic [7:0] c, input logic seq_end);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= seq_end;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // The end flag, when asked for, goes on the final character only.
    task automatic send_str(input string bases, input logic end_seq);
        for (int i = 0; i < bases.len(); i++)
            send_base(bases[i], end_seq && (i == bases.len() - 1));
    endtask

    // Holds the sender off until every record has come, then lets the
    // pipeline settle, since an item may still be in flight with no record.
    task automatic drain_records();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_mask(input logic enable);
        cfg_valid <= 1'b1;
        cfg_data  <= enable;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_base(output logic [7:0] c);
        string upper_set;
        string lower_set;
        upper_set = "ACGT";
        lower_set = "acgt";
        // Repeating the previous character now and then builds longer runs.
        if ($urandom_range(0, 2) == 0) begin
            c = prev_base;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: c = upper_set[$urandom_range(0, 3)];
                4, 5:       c = lower_set[$urandom_range(0, 3)];
                6:          c = ($urandom_range(0, 1) == 0) ? "N" : "n";
                7:          c = 8'($urandom_range("a", "z"));
                default:    c = 8'($urandom_range(0, 255));
            endcase
        end
        prev_base = c;
    endtask

    task automatic random_phase(input int n_items, input logic enable);
        int         sent;
        int         len;
        logic [7:0] c;
        logic       seq_end;
        sent = 0;
        drain_records();
        write_mask(enable);
        while (sent < n_items) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
                pick_base(c);
                seq_end = (i == len - 1);
                // A few sequences end early or run on into the next one.
                if ($urandom_range(0, 19) == 0)
                    seq_end = ~seq_end;
                send_base(c, seq_end);
                sent++;
            end
            // Mid-phase pause with a mask change while the block is quiet.
            if (sent >= n_items / 2 && sent - len < n_items / 2) begin
                drain_records();
                write_mask(1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'd0;
        s_tlast       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        src_idle_pct  = 23;
        sink_idle_pct = 64;
        prev_base     = "A";
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with masking on as after reset.
        send_str("TCAG", 1'b0);
        send_str("acgt", 1'b0);
        // An N ends the lower-case run; n carries on the N run and opens
        // a mask run; A then closes both in the same item.
        send_str("NnA", 1'b0);
        send_base(8'h00, 1'b0);
        send_base(8'hFF, 1'b0);
        send_str("z", 1'b1);
        // Sequence end inside an N run and a mask run gives three records.
        send_str("Nn", 1'b1);
        send_str("G", 1'b1);
        // Mask switched off while a lower-case run is open.
        send_str("ttt", 1'b0);
        drain_records();
        write_mask(1'b0);
        send_str("txN", 1'b1);
        drain_records();
        write_mask(1'b1);

        random_phase(28, 1'b1);
        src_idle_pct  = 64;
        sink_idle_pct = 23;
        random_phase(28, 1'b0);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_phase(28, 1'b1);

        drain_records();
        @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("dna_two_bit_packer_core: match");
        else
            $display("dna_two_bit_packer_core: mismatch");
        $finish;
    end

endmodule

// ----- dna_two_bit_packer_core.f -----
+incdir+rtl/core
rtl/core/dtbp_pkg.sv
rtl/core/dtbp_step.sv
rtl/core/dna_two_bit_packer_core.sv
tb/dtbp_checker.sv
tb/tb.sv
